/* rtl/iloc_pkg.sv */
package iloc_pkg;

  localparam int NUM_REGS = 64;
  localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int XLEN = 64;
  localparam int CNT_W = $clog2(XLEN + 1);

  typedef enum logic [4:0] {
    F_NOP = 5'd0, F_ADD = 5'd1, F_SUB = 5'd2, F_MULT = 5'd3, F_DIV = 5'd4,
    F_ADDI = 5'd5, F_SUBI = 5'd6, F_RSUBI = 5'd7, F_MULTI = 5'd8, F_DIVI = 5'd9,
    F_RDIVI = 5'd10, F_LSHIFT = 5'd11, F_LSHIFTI = 5'd12, F_RSHIFT = 5'd13,
    F_RSHIFTI = 5'd14, F_AND = 5'd15, F_ANDI = 5'd16, F_OR = 5'd17,
    F_ORI = 5'd18, F_XOR = 5'd19, F_XORI = 5'd20
  } func_t;

  typedef enum logic [2:0] {
    U_ADD, U_SUB, U_MUL, U_DIV, U_SHL, U_SHR, U_AND, U_OR
  } uop_t;

  localparam uop_t U_XOR = U_OR;

  // Control passed from the sequencer to the shared unit.
  typedef struct packed {
    logic start;
    uop_t op;
    logic use_xor;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

  function automatic logic [REG_AW-1:0] reg_idx(input logic [5:0] idx);
    logic [31:0] wide;
    wide = 32'(idx) % NUM_REGS;
    return wide[REG_AW-1:0];
  endfunction

endpackage

/* rtl/iloc_if.sv */
interface iloc_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] func;
  logic [5:0] src_a;
  logic [5:0] src_b;
  logic signed [63:0] immediate;
  logic [5:0] dest;
  modport source(output valid, func, src_a, src_b, immediate, dest, input ready);
  modport sink(input valid, func, src_a, src_b, immediate, dest, output ready);
endinterface

interface iloc_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       wrote;
  logic [5:0] dest_index;
  logic signed [63:0] value;
  modport source(output valid, status, wrote, dest_index, value, input ready);
  modport sink(input valid, status, wrote, dest_index, value, output ready);
endinterface

/* rtl/iloc_unit.sv */
module iloc_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iloc_pkg::unit_ctl_t    ctl,
  input  logic [63:0]            opa,
  input  logic [63:0]            opb,
  output iloc_pkg::unit_sts_t    sts,
  output logic [63:0]            result
);
  import iloc_pkg::*;

  // Multi-cycle datapath: an adder accumulates partial products for multiply and a
  // trial subtractor tries the subtraction for division; shifts use neither.
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mc_r, mc_nxt;       // multiplicand / divisor magnitude / shiftee
  logic [63:0] ml_r, ml_nxt;       // multiplier / dividend quotient shifter
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic neg_r, neg_nxt;
  uop_t op_r, op_nxt;
  logic [63:0] res_r, res_nxt;

  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] mag_a, mag_b;

  assign mag_a = opa[63] ? (64'd0 - opa) : opa;
  assign mag_b = opb[63] ? (64'd0 - opb) : opb;
  assign rem_sh = {acc_r[62:0], ml_r[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, mc_r};

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    ml_nxt = ml_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt = neg_r;
    op_nxt = op_r;
    res_nxt = res_r;
    if (ctl.start) begin
      op_nxt = ctl.op;
      busy_nxt = 1'b0;
      case (ctl.op)
        U_ADD: begin res_nxt = opa + opb; done_nxt = 1'b1; end
        U_SUB: begin res_nxt = opa - opb; done_nxt = 1'b1; end
        U_AND: begin res_nxt = opa & opb; done_nxt = 1'b1; end
        U_OR: begin
          res_nxt = ctl.use_xor ? (opa ^ opb) : (opa | opb);
          done_nxt = 1'b1;
        end
        U_MUL: begin
          acc_nxt = '0; mc_nxt = opa; ml_nxt = opb;
          cnt_nxt = CNT_W'(XLEN); busy_nxt = 1'b1;
        end
        U_DIV: begin
          acc_nxt = '0; mc_nxt = mag_b; ml_nxt = mag_a;
          neg_nxt = opa[63] ^ opb[63];
          cnt_nxt = CNT_W'(XLEN); busy_nxt = 1'b1;
        end
        U_SHL, U_SHR: begin
          mc_nxt = opa; cnt_nxt = CNT_W'(opb[5:0]); busy_nxt = 1'b1;
        end
        default: begin res_nxt = '0; done_nxt = 1'b1; end
      endcase
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        case (op_r)
          U_MUL: res_nxt = acc_r;
          U_DIV: res_nxt = neg_r ? (64'd0 - ml_r) : ml_r;
          default: res_nxt = mc_r;
        endcase
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        case (op_r)
          U_MUL: begin
            if (ml_r[0]) acc_nxt = acc_r + mc_r;
            mc_nxt = {mc_r[62:0], 1'b0};
            ml_nxt = {1'b0, ml_r[63:1]};
          end
          U_DIV: begin
            // Restoring step: one quotient bit per cycle.
            if (!trial[64]) begin
              acc_nxt = trial[63:0];
              ml_nxt = {ml_r[62:0], 1'b1};
            end else begin
              acc_nxt = rem_sh;
              ml_nxt = {ml_r[62:0], 1'b0};
            end
          end
          U_SHL: mc_nxt = {mc_r[62:0], 1'b0};
          default: mc_nxt = {mc_r[63], mc_r[63:1]};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    ml_r <= ml_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    op_r <= op_nxt;
    res_r <= res_nxt;
  end

  assign sts.done = done_r;
  assign result = res_r;
endmodule

/* rtl/iloc_register_alu.sv */
// Channel | Direction | Payload
// in_     | sink      | func, src_a, src_b, immediate, dest
// out_    | source    | status, wrote, dest_index, value
// One instruction at a time, through S_IDLE, S_READ and S_ISSUE; nop and traps go
// straight to S_OUT, the rest wait in S_WAIT for the shared unit: shifts step
// once per bit of shift amount, mult and div run its one-bit-per-cycle loop.
// After reset a clearing pass zeroes the register file, one entry a cycle,
// with in_ready low. A stalled result holds the block.
module iloc_register_alu (
  input logic clk,
  input logic rst_n,
  iloc_in_if.sink    in_ch,
  iloc_out_if.source out_ch
);
  import iloc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_ISSUE, S_WAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [63:0] rf [NUM_REGS];
  logic [REG_AW-1:0] clr_r;
  logic [4:0] func_r;
  logic [REG_AW-1:0] ia_r, ib_r;
  logic [63:0] imm_r;
  logic [5:0] dest_r;
  logic [63:0] a_r, b_r;
  logic [63:0] opa, opb;
  logic trap, wr_en, is_wr;
  uop_t op;
  logic use_xor;
  unit_ctl_t ctl;
  unit_sts_t sts;
  logic [63:0] ures;
  logic out_status_r, out_wrote_r;
  logic [63:0] out_value_r;

  always_comb begin
    opa = a_r; opb = b_r; op = U_ADD; use_xor = 1'b0; is_wr = 1'b1; trap = 1'b0;
    case (func_r)
      F_ADD: op = U_ADD;
      F_SUB: op = U_SUB;
      F_MULT: op = U_MUL;
      F_DIV: begin op = U_DIV; trap = (b_r == '0); end
      F_ADDI: begin op = U_ADD; opb = imm_r; end
      F_SUBI: begin op = U_SUB; opb = imm_r; end
      F_RSUBI: begin op = U_SUB; opa = imm_r; opb = a_r; end
      F_MULTI: begin op = U_MUL; opb = imm_r; end
      F_DIVI: begin op = U_DIV; opb = imm_r; trap = (imm_r == '0); end
      F_RDIVI: begin op = U_DIV; opa = imm_r; opb = a_r; trap = (a_r == '0); end
      F_LSHIFT: op = U_SHL;
      F_LSHIFTI: begin op = U_SHL; opb = imm_r; end
      F_RSHIFT: op = U_SHR;
      F_RSHIFTI: begin op = U_SHR; opb = imm_r; end
      F_AND: op = U_AND;
      F_ANDI: begin op = U_AND; opb = imm_r; end
      F_OR: op = U_OR;
      F_ORI: begin op = U_OR; opb = imm_r; end
      F_XOR: begin op = U_XOR; use_xor = 1'b1; end
      F_XORI: begin op = U_XOR; use_xor = 1'b1; opb = imm_r; end
      default: is_wr = 1'b0;
    endcase
  end

  assign ctl.start = (state_r == S_ISSUE) && is_wr && !trap;
  assign ctl.op = op;
  assign ctl.use_xor = use_xor;
  assign wr_en = (state_r == S_WAIT) && sts.done;

  iloc_unit u_unit (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(opb),
    .sts(sts), .result(ures)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) rf[clr_r] <= '0;
    else if (wr_en) rf[reg_idx(dest_r)] <= ures;
    if (state_r == S_READ) begin
      a_r <= rf[ia_r];
      b_r <= rf[ib_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == NUM_REGS - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) state_r <= S_READ;
        S_READ: state_r <= S_ISSUE;
        S_ISSUE: begin
          if (is_wr && !trap) state_r <= S_WAIT;
          else begin
            out_status_r <= trap;
            out_wrote_r <= 1'b0;
            out_value_r <= '0;
            state_r <= S_OUT;
          end
        end
        S_WAIT: if (sts.done) begin
          out_status_r <= 1'b0;
          out_wrote_r <= 1'b1;
          out_value_r <= ures;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_IDLE) begin
      func_r <= in_ch.func;
      ia_r <= reg_idx(in_ch.src_a);
      ib_r <= reg_idx(in_ch.src_b);
      imm_r <= in_ch.immediate;
      dest_r <= in_ch.dest;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = out_status_r;
  assign out_ch.wrote = out_wrote_r;
  assign out_ch.dest_index = dest_r;
  assign out_ch.value = out_value_r;
endmodule

/* rtl/iloc_checker.sv */
module iloc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic out_wrote,
  input logic [63:0] out_value
);
  a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_wrote && out_value == '0)
    else $error("trap result claims a write");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wrote |-> out_value == '0)
    else $error("unwritten result carries a value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("pending result dropped or changed");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");
endmodule

bind iloc_register_alu iloc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_wrote(out_ch.wrote),
  .out_value(out_ch.value)
);
